### hdl/mpd_pkg.sv
// Shared types and constants for the mouse packet deframer.
// No dependencies; imported by every module of the block.
package mpd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned FIELDS  = 4;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

  typedef enum logic [2:0] {
    ST_TAKEN   = 3'd0,
    ST_DISCARD = 3'd1,
    ST_REPORT  = 3'd2,
    ST_BADSUM  = 3'd3,
    ST_DROPPED = 3'd4
  } status_e;

  typedef struct packed {
    status_e                   status;
    logic [BYTE_W-1:0]         buttons;
    logic signed [BYTE_W-1:0]  dx;
    logic signed [BYTE_W-1:0]  dy;
    logic signed [BYTE_W-1:0]  wheel;
    logic [COUNT_W-1:0]        good;
    logic [COUNT_W-1:0]        bad;
    logic [COUNT_W-1:0]        seen;
  } mpd_result_t;

endpackage

### hdl/mouse_packet_deframer.sv
// Mouse packet deframer: header hunt, four field bytes, additive checksum.
// Each input byte passes through the input register, then the result register.
// Throughput: one byte per cycle while out_ready_i does not stall; one new byte is taken while a result waits.
// Reset (async, active low): hunting, header 0xAA, counters and fields zero.
// Depends on mpd_pkg, mpd_in_stage, mpd_deframe, mpd_out_stage.
module mouse_packet_deframer import mpd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // received byte channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [BYTE_W-1:0]        rx_byte_i,
  input  logic                     host_ready_i,
  // per-byte status channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               status_o,
  output logic [BYTE_W-1:0]        report_buttons_o,
  output logic signed [BYTE_W-1:0] report_dx_o,
  output logic signed [BYTE_W-1:0] report_dy_o,
  output logic signed [BYTE_W-1:0] report_wheel_o,
  output logic [COUNT_W-1:0]       good_packets_o,
  output logic [COUNT_W-1:0]       bad_packets_o,
  output logic [COUNT_W-1:0]       bytes_seen_o,
  // header register write
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [BYTE_W-1:0]        header_value_i
);

  logic              item_valid;
  logic [BYTE_W-1:0] item_byte;
  logic              item_host;
  logic              out_free;
  logic              step;
  mpd_result_t       next_res;
  mpd_result_t       out_res;

  // The header register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // A byte moves from the input register into the result register when the
  // result register is empty or draining in the same cycle.
  assign step = item_valid && out_free;

  mpd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .host_ready_i (host_ready_i),
    .take_i       (step),
    .valid_o      (item_valid),
    .byte_o       (item_byte),
    .host_ready_o (item_host)
  );

  // Framing state only moves on a step, so each byte is processed once.
  mpd_deframe u_deframe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .header_value_i (header_value_i),
    .step_i         (step),
    .rx_byte_i      (item_byte),
    .host_ready_i   (item_host),
    .result_o       (next_res)
  );

  mpd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (next_res),
    .free_o      (out_free),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .result_o    (out_res)
  );

  assign status_o         = out_res.status;
  assign report_buttons_o = out_res.buttons;
  assign report_dx_o      = out_res.dx;
  assign report_dy_o      = out_res.dy;
  assign report_wheel_o   = out_res.wheel;
  assign good_packets_o   = out_res.good;
  assign bad_packets_o    = out_res.bad;
  assign bytes_seen_o     = out_res.seen;

  // Report fields are zero on every status other than a report.
  a_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_REPORT |->
      report_buttons_o == '0 && report_dx_o == '0 &&
      report_dy_o == '0 && report_wheel_o == '0)
    else $error("report fields set without a report");

endmodule

### hdl/mpd_in_stage.sv
// Input register for received bytes.
// Depends on mpd_pkg.
module mpd_in_stage import mpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic              host_ready_i,
  input  logic              take_i,
  output logic              valid_o,
  output logic [BYTE_W-1:0] byte_o,
  output logic              host_ready_o
);

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q;
  logic              host_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) ? 1'b1 :
                      (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
      host_q <= host_ready_i;
    end
  end

  assign valid_o      = valid_q;
  assign byte_o       = byte_q;
  assign host_ready_o = host_q;

endmodule

### hdl/mpd_deframe.sv
// Deframing state, field store, counters and per-byte result logic.
// Depends on mpd_pkg.
module mpd_deframe import mpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [BYTE_W-1:0] header_value_i,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic              host_ready_i,
  output mpd_result_t       result_o
);

  localparam logic [2:0] POS_HUNT  = 3'd0;
  localparam logic [2:0] POS_FIRST = 3'd1;
  localparam logic [2:0] POS_LAST  = 3'd4;
  localparam logic [2:0] POS_CHECK = 3'd5;

  logic [2:0]         pos_q, pos_d;
  logic [BYTE_W-1:0]  header_q;
  logic [BYTE_W-1:0]  field_q [FIELDS];
  logic [COUNT_W-1:0] good_q, good_d;
  logic [COUNT_W-1:0] bad_q, bad_d;
  logic [COUNT_W-1:0] seen_q, seen_d;
  logic [BYTE_W-1:0]  sum;
  logic [1:0]         field_idx;
  logic               store_en;
  mpd_result_t        res;

  assign sum       = field_q[0] + field_q[1] + field_q[2] + field_q[3];
  assign field_idx = pos_q[1:0] - 2'd1;

  always_comb begin
    pos_d       = pos_q;
    good_d      = good_q;
    bad_d       = bad_q;
    seen_d      = seen_q + 32'd1;
    store_en    = 1'b0;
    res         = '0;
    res.status  = ST_DISCARD;
    priority if (pos_q >= POS_FIRST && pos_q <= POS_LAST) begin
      store_en   = 1'b1;
      pos_d      = pos_q + 3'd1;
      res.status = ST_TAKEN;
    end else if (pos_q == POS_CHECK) begin
      pos_d = POS_HUNT;
      priority if (sum != rx_byte_i) begin
        bad_d      = bad_q + 32'd1;
        res.status = ST_BADSUM;
      end else if (host_ready_i) begin
        good_d      = good_q + 32'd1;
        res.status  = ST_REPORT;
        res.dx      = field_q[0];
        res.dy      = field_q[1];
        res.buttons = field_q[2];
        res.wheel   = field_q[3];
      end else begin
        res.status = ST_DROPPED;
      end
    end else begin
      // hunting; stray codes fall here too
      if (rx_byte_i == header_q) begin
        pos_d      = POS_FIRST;
        res.status = ST_TAKEN;
      end else begin
        pos_d      = POS_HUNT;
        res.status = ST_DISCARD;
      end
    end
    res.good = good_d;
    res.bad  = bad_d;
    res.seen = seen_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_HUNT;
      header_q   <= HEADER_RESET;
      good_q     <= '0;
      bad_q      <= '0;
      seen_q     <= '0;
      field_q[0] <= '0;
      field_q[1] <= '0;
      field_q[2] <= '0;
      field_q[3] <= '0;
    end else begin
      if (cfg_valid_i) begin
        header_q <= header_value_i;
      end
      if (step_i) begin
        pos_q  <= pos_d;
        good_q <= good_d;
        bad_q  <= bad_d;
        seen_q <= seen_d;
        if (store_en) begin
          field_q[field_idx] <= rx_byte_i;
        end
      end
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_CHECK)
    else $error("byte position out of range");

  a_seen_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> seen_q == $past(seen_q) + 32'd1)
    else $error("byte count did not advance");

  a_check_rehunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && pos_q == POS_CHECK |=> pos_q == POS_HUNT)
    else $error("no return to hunting after checksum byte");

endmodule

### hdl/mpd_out_stage.sv
// Result register on the output channel.
// Depends on mpd_pkg.
module mpd_out_stage import mpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  mpd_result_t result_i,
  output logic        free_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output mpd_result_t result_o
);

  logic        valid_q, valid_d;
  mpd_result_t result_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

### test/tb_mouse_packet_deframer.sv
// Self-checking testbench for mouse_packet_deframer: header hunt, field capture, checksum.
// Depends on mpd_pkg and the RTL under hdl/. It runs a directed table first, then random
// packet traffic under several header settings with random stalls on both channels.
module tb_mouse_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import mpd_pkg::*;

  localparam logic [2:0] POS_HUNT = 3'd0;   // waiting for a header byte
  localparam logic [2:0] POS_SUM  = 3'd5;   // checksum byte comes next
  localparam int         PHASE_ITEMS = 235;
  localparam int         DIR_ROWS    = 26;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BYTE_W-1:0]  rx_byte  = '0;
  logic               host_rdy = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         st_out;
  logic [BYTE_W-1:0]  btn_out;
  logic signed [BYTE_W-1:0] dx_out, dy_out, wh_out;
  logic [COUNT_W-1:0] good_out, bad_out, seen_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [BYTE_W-1:0]  hdr_wr    = '0;

  mouse_packet_deframer u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .rx_byte_i       (rx_byte),
    .host_ready_i    (host_rdy),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (st_out),
    .report_buttons_o(btn_out),
    .report_dx_o     (dx_out),
    .report_dy_o     (dy_out),
    .report_wheel_o  (wh_out),
    .good_packets_o  (good_out),
    .bad_packets_o   (bad_out),
    .bytes_seen_o    (seen_out),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .header_value_i  (hdr_wr)
  );

  // ---------------------------------------------------------------------------
  // Deframer predictor: its own copy of the header register and all state
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]  hdr_model  = HEADER_RESET;
  logic [2:0]         pos_model  = POS_HUNT;
  logic [BYTE_W-1:0]  fld_model [FIELDS] = '{default: '0};
  logic [COUNT_W-1:0] good_model = '0;
  logic [COUNT_W-1:0] bad_model  = '0;
  logic [COUNT_W-1:0] seen_model = '0;

  mpd_result_t pending_status [$];   // per-byte status still owed by the DUT
  int          err_count = 0;
  bit          tx_calm   = 1'b0;     // sender burst mode: no gaps
  bit          rx_calm   = 1'b0;     // receiver burst mode: no stalls

  function automatic mpd_result_t deframe_byte(logic [BYTE_W-1:0] b, logic rdy);
    mpd_result_t r;
    logic [BYTE_W-1:0] sum;
    r = '0;
    seen_model++;
    if (pos_model >= 3'd1 && pos_model <= 3'd4) begin
      fld_model[2'(pos_model - 3'd1)] = b;
      pos_model++;
      r.status = ST_TAKEN;
    end else if (pos_model == POS_SUM) begin
      sum = fld_model[0] + fld_model[1] + fld_model[2] + fld_model[3];
      pos_model = POS_HUNT;
      if (sum != b) begin
        bad_model++;
        r.status = ST_BADSUM;
      end else if (rdy) begin
        good_model++;
        r.status  = ST_REPORT;
        r.dx      = fld_model[0];
        r.dy      = fld_model[1];
        r.buttons = fld_model[2];
        r.wheel   = fld_model[3];
      end else begin
        r.status = ST_DROPPED;
      end
    end else begin
      // hunting; the unused codes 6 and 7 behave the same way
      if (b == hdr_model) begin
        pos_model = 3'd1;
        r.status  = ST_TAKEN;
      end else begin
        pos_model = POS_HUNT;
        r.status  = ST_DISCARD;
      end
    end
    r.good = good_model;
    r.bad  = bad_model;
    r.seen = seen_model;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: rows with a pinned result are compared with that result,
  // the rest with the predictor
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              rdy;
    bit                pinned;
    mpd_result_t       want;
  } dir_row_t;

  function automatic mpd_result_t res(status_e st, logic [7:0] btn, logic [7:0] dx,
                                      logic [7:0] dy, logic [7:0] wh,
                                      logic [31:0] g, logic [31:0] bd, logic [31:0] s);
    mpd_result_t r;
    r.status  = st;
    r.buttons = btn;
    r.dx      = dx;
    r.dy      = dy;
    r.wheel   = wh;
    r.good    = g;
    r.bad     = bd;
    r.seen    = s;
    return r;
  endfunction

  function automatic dir_row_t fwd(logic [7:0] b, logic rdy);
    dir_row_t row;
    row.data   = b;
    row.rdy    = rdy;
    row.pinned = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic dir_row_t pin(logic [7:0] b, logic rdy, mpd_result_t want);
    dir_row_t row;
    row        = fwd(b, rdy);
    row.pinned = 1'b1;
    row.want   = want;
    return row;
  endfunction

  dir_row_t dir_rows [DIR_ROWS];

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Returns in the time step of the accepting edge with valid still high, so a
  // back-to-back transaction only updates the payload. Callers that stop
  // sending lower valid in that same step (see settle).
  task automatic send_byte(input logic [7:0] b, input logic rdy,
                           input bit pinned = 1'b0, input mpd_result_t want = '0);
    int          gap;
    mpd_result_t pred;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    host_rdy <= rdy;
    do @(posedge clk); while (!in_ready);
    pred = deframe_byte(b, rdy);
    pending_status.push_back(pinned ? want : pred);
  endtask

  // Hold off until every status transaction has come back, then let the
  // two-stage pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Header register write; only called while the block is idle.
  task automatic write_header(input logic [7:0] v);
    cfg_valid <= 1'b1;
    hdr_wr    <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hdr_model = v;
  endtask

  // Field bytes lean toward sign and magnitude corners.
  function automatic logic [7:0] field_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed packets with random content; some noise between them
  // and some packets cut short, whose tail then swallows the next bytes.
  task automatic run_phase(input int n_items);
    int          sent;
    int          cut;
    logic [7:0]  f [FIELDS];
    logic [7:0]  sum;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 199) == 0) settle();
      case ($urandom_range(0, 9))
        0, 1: begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          sent++;
        end
        2: begin
          cut = $urandom_range(0, 3);
          send_byte(hdr_model, 1'($urandom_range(0, 1)));
          for (int k = 0; k < cut; k++) send_byte(field_byte(), 1'($urandom_range(0, 1)));
          sent += cut + 1;
        end
        default: begin
          send_byte(hdr_model, 1'($urandom_range(0, 1)));
          sum = '0;
          for (int k = 0; k < FIELDS; k++) begin
            f[k] = field_byte();
            sum += f[k];
            send_byte(f[k], 1'($urandom_range(0, 1)));
          end
          if ($urandom_range(0, 4) == 0) sum ^= 8'(1 << $urandom_range(0, 7));
          send_byte(sum, $urandom_range(0, 3) != 0);
          sent += FIELDS + 2;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, each transaction checked field by field
  // ---------------------------------------------------------------------------
  task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endtask

  initial begin : status_sink
    int          stall;
    mpd_result_t want;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_status.size() == 0) begin
        $error("status transaction with nothing expected");
        err_count++;
      end else begin
        want = pending_status.pop_front();
        cmp("status",         32'(want.status),  32'(st_out));
        cmp("report_buttons", 32'(want.buttons), 32'(btn_out));
        cmp("report_dx",      32'(want.dx),      32'(dx_out));
        cmp("report_dy",      32'(want.dy),      32'(dy_out));
        cmp("report_wheel",   32'(want.wheel),   32'(wh_out));
        cmp("good_packets",   want.good,         good_out);
        cmp("bad_packets",    want.bad,          bad_out);
        cmp("bytes_seen",     want.seen,         seen_out);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] phase_hdr [6];
    phase_hdr = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), HEADER_RESET,
                  8'($urandom_range(0, 255)), 8'h7F};

    // reset header is 0xAA; counters start at zero, so the pinned rows are exact
    dir_rows = '{
      pin(8'h00, 1'b0, res(ST_DISCARD, 0, 0, 0, 0, 0, 0, 1)),
      pin(8'hFF, 1'b1, res(ST_DISCARD, 0, 0, 0, 0, 0, 0, 2)),
      pin(8'hAA, 1'b0, res(ST_TAKEN,   0, 0, 0, 0, 0, 0, 3)),
      fwd(8'h7F, 1'b1), fwd(8'h80, 1'b0), fwd(8'hFF, 1'b1), fwd(8'h01, 1'b0),
      // sum 7F+80+FF+01 wraps to FF; host ready gives a report
      pin(8'hFF, 1'b1, res(ST_REPORT, 8'hFF, 8'h7F, 8'h80, 8'h01, 1, 0, 8)),
      // header byte inside a packet is plain data
      fwd(8'hAA, 1'b1), fwd(8'hAA, 1'b0), fwd(8'h00, 1'b1), fwd(8'h00, 1'b0),
      fwd(8'h00, 1'b1),
      pin(8'h55, 1'b1, res(ST_BADSUM, 0, 0, 0, 0, 1, 1, 14)),
      // good checksum, host not ready: packet dropped
      fwd(8'hAA, 1'b0), fwd(8'h80, 1'b1), fwd(8'h80, 1'b0), fwd(8'h80, 1'b1),
      fwd(8'h80, 1'b0),
      pin(8'h00, 1'b0, res(ST_DROPPED, 0, 0, 0, 0, 1, 1, 20)),
      fwd(8'hAA, 1'b1), fwd(8'h01, 1'b0), fwd(8'h02, 1'b1), fwd(8'h03, 1'b0),
      fwd(8'h04, 1'b0), fwd(8'h0A, 1'b1)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].data, dir_rows[i].rdy, dir_rows[i].pinned, dir_rows[i].want);
    settle();

    // random traffic, one header setting per phase, written while idle
    foreach (phase_hdr[p]) begin
      write_header(phase_hdr[p]);
      run_phase(PHASE_ITEMS);
      settle();
    end

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
